// ===== src/pwm_timing_calculator_macros.svh =====
// Assertion macros shared by the PWM timing calculator RTL.
`ifndef PWM_TIMING_CALCULATOR_MACROS_SVH
`define PWM_TIMING_CALCULATOR_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PWM_TC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define PWM_TC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pwm_tc_pkg.sv =====
// Types, constants and prescaler ladder for the PWM timing calculator.
package pwm_tc_pkg;

   // Field widths
   localparam int unsigned CPU_W      = 8;
   localparam int unsigned PWM_W      = 24;
   localparam int unsigned DEAD_W     = 16;
   localparam int unsigned DUTY_W     = 14;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned KDIV_W     = 10;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned CSR_IDX_W  = 2;

   // Timing unit widths
   localparam int unsigned CLKHZ_W    = 28;   // 255 MHz in Hz fits
   localparam int unsigned THR_W      = 27;   // 768 * 131060
   localparam int unsigned PROD_W     = 52;   // (pwm + 1) * threshold step
   localparam int unsigned NUM_W      = 28;   // divider dividend and quotient
   localparam int unsigned DEN_W      = 35;   // 2 * pwm * k
   localparam int unsigned DIV_CNT_W  = 5;

   // Compare lane widths
   localparam int unsigned LANE_PROD_W   = 30;
   localparam int unsigned RECIP_SHIFT   = 30;
   localparam int unsigned LANE_SCALED_W = 47;

   // Constants
   localparam int unsigned HZ_PER_MHZ  = 1000000;
   localparam int unsigned PERIOD_MAX  = 65530;
   localparam int unsigned THR_SCALE   = 2 * PERIOD_MAX;
   localparam int unsigned NS_PER_US   = 1000;
   localparam int unsigned DUTY_FULL   = 10000;
   localparam longint unsigned DUTY_RECIP = (64'd1 << RECIP_SHIFT) / DUTY_FULL;

   localparam logic [CNT_W-1:0] CNT_SAT = '1;

   // Prescaler ladder
   localparam int unsigned LADDER_LEN = 31;
   localparam int unsigned LADDER_IDX_W = 5;
   localparam logic [LADDER_IDX_W-1:0] LADDER_LAST = LADDER_IDX_W'(LADDER_LEN - 1);

   localparam logic [KDIV_W-1:0] LADDER_K [LADDER_LEN] = '{
      10'd1,   10'd2,   10'd4,   10'd6,   10'd8,   10'd10,  10'd12,  10'd14,
      10'd16,  10'd20,  10'd24,  10'd32,  10'd40,  10'd48,  10'd56,  10'd64,
      10'd80,  10'd96,  10'd112, 10'd128, 10'd144, 10'd160, 10'd192, 10'd224,
      10'd256, 10'd320, 10'd384, 10'd448, 10'd512, 10'd640, 10'd768
   };

   localparam logic [CODE_W-1:0] LADDER_HSP [LADDER_LEN] = '{
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
      3'd0, 3'd5, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd0,
      3'd5, 3'd6, 3'd7, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7,
      3'd4, 3'd5, 3'd6, 3'd7, 3'd4, 3'd5, 3'd6
   };

   localparam logic [CODE_W-1:0] LADDER_CLK [LADDER_LEN] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd4, 3'd1, 3'd2, 3'd5, 3'd2, 3'd2, 3'd2, 3'd6,
      3'd3, 3'd3, 3'd3, 3'd7, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6
   };

   // Threshold step k * 2 * 65530 of a ladder entry
   function automatic logic [THR_W-1:0] ladder_thr(input logic [LADDER_IDX_W-1:0] idx);
      logic [31:0] full;
      full = 32'(LADDER_K[idx]) * 32'(THR_SCALE);
      return full[THR_W-1:0];
   endfunction

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CPU_FREQ      = 2'd0,
      CSR_PWM_FREQ      = 2'd1,
      CSR_DEAD_TIME     = 2'd2,
      CSR_COMPLEMENTARY = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      SETUP_CLK,
      SETUP_SEL_MUL,
      SETUP_SEL_CMP,
      SETUP_PER_MUL,
      SETUP_PER_GO,
      SETUP_PER_WAIT,
      SETUP_DB_MUL,
      SETUP_DB_GO,
      SETUP_DB_WAIT,
      SETUP_READY
   } setup_state_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
   } req_payload_type;

   typedef struct packed {
      logic [CNT_W-1:0]  period_count;
      logic [CODE_W-1:0] high_speed_div_code;
      logic [CODE_W-1:0] clock_div_code;
      logic [KDIV_W-1:0] total_divide;
      logic [CNT_W-1:0]  compare_a;
      logic [CNT_W-1:0]  compare_b;
      logic [CNT_W-1:0]  dead_band_count;
      logic              dead_band_mode;
      logic              saturated;
   } rsp_payload_type;

   // Timing words from the setup unit
   typedef struct packed {
      logic              ok;
      logic [CNT_W-1:0]  period;
      logic [CODE_W-1:0] hsp_code;
      logic [CODE_W-1:0] clk_code;
      logic [KDIV_W-1:0] k;
      logic [CNT_W-1:0]  dead;
      logic              mode;
      logic              sat;
   } timing_type;

   // Stage load strobes shared by the compare lanes
   typedef struct packed {
      logic ld1;
      logic ld2;
   } lane_ctl_type;

endpackage

// ===== src/pwm_tc_if.sv =====
// Valid/ready channel carrying one payload beat.
interface pwm_tc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/pwm_tc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pwm_tc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pwm_tc_pkg::NUM_W-1:0]  num,
   input  logic [pwm_tc_pkg::DEN_W-1:0]  den,
   output logic                          done,
   output logic [pwm_tc_pkg::NUM_W-1:0]  quot
);

   localparam logic [pwm_tc_pkg::DIV_CNT_W-1:0] CNT_LAST =
      pwm_tc_pkg::DIV_CNT_W'(pwm_tc_pkg::NUM_W - 1);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [pwm_tc_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [pwm_tc_pkg::DEN_W-1:0]        rem_ff, rem_in;
   logic [pwm_tc_pkg::DEN_W-1:0]        den_ff, den_in;
   logic [pwm_tc_pkg::NUM_W-1:0]        quo_ff, quo_in;
   logic [pwm_tc_pkg::DEN_W:0]          rem_sh;
   logic [pwm_tc_pkg::DEN_W:0]          rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff, quo_ff[pwm_tc_pkg::NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         // shift in the next dividend bit, keep the difference if it fits
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[pwm_tc_pkg::DEN_W-1:0];
            quo_in = {quo_ff[pwm_tc_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[pwm_tc_pkg::DEN_W-1:0];
            quo_in = {quo_ff[pwm_tc_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ===== src/pwm_tc_setup.sv =====
// Configuration registers and timing-word sequencer (prescaler, period, dead band).
module pwm_tc_setup (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pwm_tc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwm_tc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output pwm_tc_pkg::timing_type             timing
);

   pwm_tc_pkg::setup_state_type state_ff, state_in;

   logic [pwm_tc_pkg::CPU_W-1:0]        cpu_ff, cpu_in;
   logic [pwm_tc_pkg::PWM_W-1:0]        pwm_ff, pwm_in;
   logic [pwm_tc_pkg::DEAD_W-1:0]       dead_ns_ff, dead_ns_in;
   logic                                comp_ff, comp_in;

   logic [pwm_tc_pkg::CLKHZ_W-1:0]      clk_hz_ff, clk_hz_in;
   logic [pwm_tc_pkg::LADDER_IDX_W-1:0] idx_ff, idx_in;
   logic [pwm_tc_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [pwm_tc_pkg::NUM_W-1:0]        num_ff, num_in;
   logic [pwm_tc_pkg::DEN_W-1:0]        den_ff, den_in;
   logic [pwm_tc_pkg::CNT_W-1:0]        period_ff, period_in;
   logic [pwm_tc_pkg::CNT_W-1:0]        dead_ff, dead_in;
   logic                                sat_ff, sat_in;

   logic                                div_start;
   logic                                div_done;
   logic [pwm_tc_pkg::NUM_W-1:0]        div_quot;
   logic                                quot_big;
   logic [pwm_tc_pkg::CNT_W-1:0]        quot_clip;
   logic [pwm_tc_pkg::KDIV_W-1:0]       k_sel;
   logic [pwm_tc_pkg::PWM_W:0]          pwm_plus1;

   assign k_sel     = pwm_tc_pkg::LADDER_K[idx_ff];
   assign pwm_plus1 = {1'b0, pwm_ff} + 1'b1;
   assign quot_big  = |div_quot[pwm_tc_pkg::NUM_W-1:pwm_tc_pkg::CNT_W];
   assign quot_clip = quot_big ? pwm_tc_pkg::CNT_SAT : div_quot[pwm_tc_pkg::CNT_W-1:0];

   always_comb begin
      state_in   = state_ff;
      cpu_in     = cpu_ff;
      pwm_in     = pwm_ff;
      dead_ns_in = dead_ns_ff;
      comp_in    = comp_ff;
      clk_hz_in  = clk_hz_ff;
      idx_in     = idx_ff;
      prod_in    = prod_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      period_in  = period_ff;
      dead_in    = dead_ff;
      sat_in     = sat_ff;
      div_start  = 1'b0;

      unique case (state_ff)
         pwm_tc_pkg::SETUP_CLK: begin
            clk_hz_in = pwm_tc_pkg::CLKHZ_W'(cpu_ff) *
                        pwm_tc_pkg::CLKHZ_W'(pwm_tc_pkg::HZ_PER_MHZ);
            idx_in    = '0;
            state_in  = pwm_tc_pkg::SETUP_SEL_MUL;
         end
         pwm_tc_pkg::SETUP_SEL_MUL: begin
            prod_in  = pwm_tc_pkg::PROD_W'(pwm_plus1) *
                       pwm_tc_pkg::PROD_W'(pwm_tc_pkg::ladder_thr(idx_ff));
            state_in = pwm_tc_pkg::SETUP_SEL_CMP;
         end
         pwm_tc_pkg::SETUP_SEL_CMP: begin
            // step qualifies when pwm >= floor(clk / thr), i.e. clk < (pwm + 1) * thr
            if ((pwm_tc_pkg::PROD_W'(clk_hz_ff) < prod_ff) ||
                (idx_ff == pwm_tc_pkg::LADDER_LAST)) begin
               state_in = pwm_tc_pkg::SETUP_PER_MUL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = pwm_tc_pkg::SETUP_SEL_MUL;
            end
         end
         pwm_tc_pkg::SETUP_PER_MUL: begin
            // zero pwm gives a zero divisor, the quotient then reads all ones and clips
            num_in   = pwm_tc_pkg::NUM_W'(clk_hz_ff);
            den_in   = (pwm_tc_pkg::DEN_W'(pwm_ff) * pwm_tc_pkg::DEN_W'(k_sel)) << 1;
            state_in = pwm_tc_pkg::SETUP_PER_GO;
         end
         pwm_tc_pkg::SETUP_PER_GO: begin
            div_start = 1'b1;
            state_in  = pwm_tc_pkg::SETUP_PER_WAIT;
         end
         pwm_tc_pkg::SETUP_PER_WAIT: begin
            if (div_done) begin
               period_in = quot_clip;
               sat_in    = quot_big;
               state_in  = pwm_tc_pkg::SETUP_DB_MUL;
            end
         end
         pwm_tc_pkg::SETUP_DB_MUL: begin
            num_in   = pwm_tc_pkg::NUM_W'(dead_ns_ff) * pwm_tc_pkg::NUM_W'(cpu_ff);
            den_in   = pwm_tc_pkg::DEN_W'(k_sel) * pwm_tc_pkg::DEN_W'(pwm_tc_pkg::NS_PER_US);
            state_in = pwm_tc_pkg::SETUP_DB_GO;
         end
         pwm_tc_pkg::SETUP_DB_GO: begin
            div_start = 1'b1;
            state_in  = pwm_tc_pkg::SETUP_DB_WAIT;
         end
         pwm_tc_pkg::SETUP_DB_WAIT: begin
            if (div_done) begin
               dead_in  = quot_clip;
               sat_in   = sat_ff | quot_big;
               state_in = pwm_tc_pkg::SETUP_READY;
            end
         end
         pwm_tc_pkg::SETUP_READY: begin
            state_in = pwm_tc_pkg::SETUP_READY;
         end
         default: begin
            state_in = pwm_tc_pkg::SETUP_CLK;
         end
      endcase

      // any register write restarts the calculation
      if (csr_we) begin
         unique case (pwm_tc_pkg::csr_index_type'(csr_index))
            pwm_tc_pkg::CSR_CPU_FREQ:      cpu_in     = csr_wdata[pwm_tc_pkg::CPU_W-1:0];
            pwm_tc_pkg::CSR_PWM_FREQ:      pwm_in     = csr_wdata[pwm_tc_pkg::PWM_W-1:0];
            pwm_tc_pkg::CSR_DEAD_TIME:     dead_ns_in = csr_wdata[pwm_tc_pkg::DEAD_W-1:0];
            pwm_tc_pkg::CSR_COMPLEMENTARY: comp_in    = csr_wdata[0];
            default: ;
         endcase
         state_in = pwm_tc_pkg::SETUP_CLK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pwm_tc_pkg::SETUP_CLK;
         cpu_ff     <= pwm_tc_pkg::CPU_W'(150);
         pwm_ff     <= pwm_tc_pkg::PWM_W'(10000);
         dead_ns_ff <= '0;
         comp_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cpu_ff     <= cpu_in;
         pwm_ff     <= pwm_in;
         dead_ns_ff <= dead_ns_in;
         comp_ff    <= comp_in;
      end
      clk_hz_ff <= clk_hz_in;
      idx_ff    <= idx_in;
      prod_ff   <= prod_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      period_ff <= period_in;
      dead_ff   <= dead_in;
      sat_ff    <= sat_in;
   end

   pwm_tc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign timing.ok       = (state_ff == pwm_tc_pkg::SETUP_READY);
   assign timing.period   = period_ff;
   assign timing.hsp_code = pwm_tc_pkg::LADDER_HSP[idx_ff];
   assign timing.clk_code = pwm_tc_pkg::LADDER_CLK[idx_ff];
   assign timing.k        = k_sel;
   assign timing.dead     = dead_ff;
   assign timing.mode     = comp_ff;
   assign timing.sat      = sat_ff;

endmodule

// ===== src/pwm_tc_lane.sv =====
// One compare lane: period * (10000 - duty) / 10000 over two stages.
module pwm_tc_lane (
   input  logic                            clock,
   input  pwm_tc_pkg::lane_ctl_type        ctl,
   input  logic [pwm_tc_pkg::DUTY_W-1:0]   duty,
   input  logic [pwm_tc_pkg::CNT_W-1:0]    period,
   output logic [pwm_tc_pkg::CNT_W-1:0]    compare
);

   localparam logic [pwm_tc_pkg::DUTY_W-1:0] DUTY_TOP =
      pwm_tc_pkg::DUTY_W'(pwm_tc_pkg::DUTY_FULL);

   logic [pwm_tc_pkg::DUTY_W-1:0]        duty_clamp;
   logic [pwm_tc_pkg::DUTY_W-1:0]        duty_rest;
   logic [pwm_tc_pkg::LANE_PROD_W-1:0]   prod_ff, prod_in;
   logic [pwm_tc_pkg::LANE_PROD_W-1:0]   keep_ff;
   logic [pwm_tc_pkg::LANE_SCALED_W-1:0] scaled_ff, scaled_in;
   logic [pwm_tc_pkg::CNT_W-1:0]         quo_est;
   logic [pwm_tc_pkg::LANE_PROD_W-1:0]   rem_est;

   assign duty_clamp = (duty > DUTY_TOP) ? DUTY_TOP : duty;
   assign duty_rest  = DUTY_TOP - duty_clamp;
   assign prod_in    = pwm_tc_pkg::LANE_PROD_W'(period) *
                       pwm_tc_pkg::LANE_PROD_W'(duty_rest);
   assign scaled_in  = pwm_tc_pkg::LANE_SCALED_W'(prod_ff) *
                       pwm_tc_pkg::LANE_SCALED_W'(pwm_tc_pkg::DUTY_RECIP);

   always_ff @(posedge clock) begin
      if (ctl.ld1) begin
         prod_ff <= prod_in;
      end
      if (ctl.ld2) begin
         scaled_ff <= scaled_in;
         keep_ff   <= prod_ff;
      end
   end

   // reciprocal estimate is low by at most one; fix it from the remainder
   assign quo_est = scaled_ff[pwm_tc_pkg::RECIP_SHIFT +: pwm_tc_pkg::CNT_W];
   assign rem_est = keep_ff - pwm_tc_pkg::LANE_PROD_W'(quo_est) *
                              pwm_tc_pkg::LANE_PROD_W'(pwm_tc_pkg::DUTY_FULL);
   assign compare = (rem_est >= pwm_tc_pkg::LANE_PROD_W'(pwm_tc_pkg::DUTY_FULL)) ?
                    quo_est + 1'b1 : quo_est;

endmodule

// ===== src/pwm_timing_calculator.sv =====
// Top level of the up-down PWM timing calculator: lanes, merge register, setup unit.
//
// Each request beat carries two duties; the response beat gives the time-base period,
// the prescaler codes, both compare values and the dead-band count. Requests are taken
// one per cycle while the response side keeps up and the timing words are ready. Each
// result passes both lane stages into an output register, so the lane stages can still
// fill while a result waits. The timing words depend only on the registers and are
// recalculated by a sequencer after reset and after every register write: a walk over
// the 31-step prescaler ladder and two restoring divisions; req_chan.ready stays low
// until that finishes. Write registers only with no beats in flight.
`include "pwm_timing_calculator_macros.svh"

module pwm_timing_calculator (
   input  logic                               clock,
   input  logic                               reset,
   pwm_tc_if.sink                             req_chan,
   pwm_tc_if.source                           rsp_chan,
   input  logic                               csr_we,
   input  logic [pwm_tc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwm_tc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pwm_tc_pkg::timing_type      timing;
   pwm_tc_pkg::lane_ctl_type    lane_ctl;
   pwm_tc_pkg::req_payload_type req_data;
   pwm_tc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                        v1_ff, v1_in;
   logic                        v2_ff, v2_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_free;
   logic                        s2_ready;
   logic                        s1_ready;
   logic                        ld_out;
   logic [pwm_tc_pkg::CNT_W-1:0] cmp_a;
   logic [pwm_tc_pkg::CNT_W-1:0] cmp_b;

   pwm_tc_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   assign req_data = req_chan.payload;

   // per-stage handshake: a stage moves when the one ahead is empty or moving
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s2_ready       = !v2_ff || out_free;
   assign s1_ready       = !v1_ff || s2_ready;
   assign req_chan.ready = timing.ok && s1_ready;

   assign lane_ctl.ld1 = req_chan.valid && req_chan.ready;
   assign lane_ctl.ld2 = v1_ff && s2_ready;
   assign ld_out       = v2_ff && out_free;

   assign v1_in        = lane_ctl.ld1 || (v1_ff && !s2_ready);
   assign v2_in        = lane_ctl.ld2 || (v2_ff && !out_free);
   assign out_valid_in = ld_out || (out_valid_ff && !rsp_chan.ready);

   pwm_tc_lane u_lane_a (
      .clock   (clock),
      .ctl     (lane_ctl),
      .duty    (req_data.duty_a),
      .period  (timing.period),
      .compare (cmp_a)
   );

   pwm_tc_lane u_lane_b (
      .clock   (clock),
      .ctl     (lane_ctl),
      .duty    (req_data.duty_b),
      .period  (timing.period),
      .compare (cmp_b)
   );

   // merge both lanes with the timing words into the output beat
   always_comb begin
      rsp_data_in                     = rsp_data_ff;
      if (ld_out) begin
         rsp_data_in.period_count        = timing.period;
         rsp_data_in.high_speed_div_code = timing.hsp_code;
         rsp_data_in.clock_div_code      = timing.clk_code;
         rsp_data_in.total_divide        = timing.k;
         rsp_data_in.compare_a           = cmp_a;
         rsp_data_in.compare_b           = cmp_b;
         rsp_data_in.dead_band_count     = timing.dead;
         rsp_data_in.dead_band_mode      = timing.mode;
         rsp_data_in.saturated           = timing.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         out_valid_ff <= out_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `PWM_TC_ASSERT_NEXT(a_write_blocks_req, csr_we, !req_chan.ready, "request taken right after a register write")
   `PWM_TC_ASSERT_NOW(a_cmp_a_in_period, rsp_chan.valid, rsp_chan.payload.compare_a <= rsp_chan.payload.period_count, "compare_a above period")
   `PWM_TC_ASSERT_NOW(a_cmp_b_in_period, rsp_chan.valid, rsp_chan.payload.compare_b <= rsp_chan.payload.period_count, "compare_b above period")
   `PWM_TC_ASSERT_NOW(a_sat_means_clip, rsp_chan.valid && rsp_chan.payload.saturated, (rsp_chan.payload.period_count == pwm_tc_pkg::CNT_SAT) || (rsp_chan.payload.dead_band_count == pwm_tc_pkg::CNT_SAT), "saturated flag without a clipped count")

endmodule

// ===== sim/pwm_timing_calculator_tb.sv =====
// Self-checking testbench for the PWM timing calculator: table-driven and random beats.
`timescale 1ns / 100ps

module pwm_timing_calculator_tb;

   localparam int LADDER_STEPS   = 31;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BEATS   = 700;
   localparam int CALM_AFTER     = 560;

   // Prescaler ladder: total divide and its two codes
   localparam int STEP_K [LADDER_STEPS] = '{
      1, 2, 4, 6, 8, 10, 12, 14, 16, 20, 24, 32, 40, 48, 56, 64,
      80, 96, 112, 128, 144, 160, 192, 224, 256, 320, 384, 448, 512, 640, 768
   };
   localparam int STEP_HSP [LADDER_STEPS] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 0, 5, 3, 0, 5, 6, 7, 0,
      5, 6, 7, 0, 4, 5, 6, 7, 4, 5, 6, 7, 4, 5, 6
   };
   localparam int STEP_CLK [LADDER_STEPS] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 4, 1, 2, 5, 2, 2, 2, 6,
      3, 3, 3, 7, 4, 4, 4, 4, 5, 5, 5, 5, 6, 6, 6
   };

   typedef enum bit {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      pwm_tc_pkg::csr_index_type     idx;
      logic [23:0]                   wdata;
      logic [13:0]                   duty_a;
      logic [13:0]                   duty_b;
      bit                            known;
      pwm_tc_pkg::rsp_payload_type   result;
   } dir_row_type;

   localparam int DIR_LEN = 35;

   logic clock;
   logic reset;
   logic csr_we;
   logic [pwm_tc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pwm_tc_pkg::CSR_DATA_W-1:0] csr_wdata;

   pwm_tc_if #(.payload_type(pwm_tc_pkg::req_payload_type)) req_if ();
   pwm_tc_if #(.payload_type(pwm_tc_pkg::rsp_payload_type)) rsp_if ();

   pwm_timing_calculator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register mirror
   longint unsigned cfg_cpu  = 150;
   longint unsigned cfg_pwm  = 10000;
   longint unsigned cfg_dead = 0;
   longint unsigned cfg_comp = 0;

   pwm_tc_pkg::rsp_payload_type timing_expected [$];
   int  errors       = 0;
   int  quiet_cycles = 0;
   bit  idle_on      = 1'b1;
   int  stall_left   = 0;

   dir_row_type dir_table [DIR_LEN] = '{
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd0, 14'd0, 1'b1,
        '{16'd7500, 3'd0, 3'd0, 10'd1, 16'd7500, 16'd7500, 16'd0, 1'b0, 1'b0}},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd10000, 14'd10000, 1'b1,
        '{16'd7500, 3'd0, 3'd0, 10'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd16383, 14'd16383, 1'b1,
        '{16'd7500, 3'd0, 3'd0, 10'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd5000, 14'd2500, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd1, 14'd9999, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_CPU_FREQ, 24'd255, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_PWM_FREQ, 24'hFFFFFF, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_DEAD_TIME, 24'd65535, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_COMPLEMENTARY, 24'd1, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd0, 14'd16383, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd10000, 14'd0, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd8191, 14'd8192, 1'b0, '0},
      // slowest carrier at the fastest clock: no step fits, period clips
      '{ROW_CSR, pwm_tc_pkg::CSR_PWM_FREQ, 24'd1, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd0, 14'd10000, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd3333, 14'd6666, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd0, 14'd0, 1'b1,
        '{16'd0, 3'd0, 3'd0, 10'd1, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0}},
      '{ROW_CSR, pwm_tc_pkg::CSR_CPU_FREQ, 24'd150, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_PWM_FREQ, 24'd0, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_DEAD_TIME, 24'd0, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_COMPLEMENTARY, 24'd0, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd0, 14'd10000, 1'b1,
        '{16'd65535, 3'd6, 3'd6, 10'd768, 16'd65535, 16'd0, 16'd0, 1'b0, 1'b1}},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd16383, 14'd5000, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_CPU_FREQ, 24'd1, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_PWM_FREQ, 24'hFFFFFF, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd9999, 14'd1, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_PWM_FREQ, 24'd1, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd7000, 14'd3000, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_CPU_FREQ, 24'd200, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_PWM_FREQ, 24'd2000, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_DEAD_TIME, 24'd1500, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_CSR, pwm_tc_pkg::CSR_COMPLEMENTARY, 24'd1, 14'd0, 14'd0, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd2500, 14'd7500, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd5461, 14'd10922, 1'b0, '0},
      '{ROW_BEAT, pwm_tc_pkg::CSR_CPU_FREQ, 24'd0, 14'd10922, 14'd5461, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pwm_tc_pkg::rsp_payload_type timing_words(
      input pwm_tc_pkg::req_payload_type beat);
      longint unsigned clk_hz;
      longint unsigned k;
      longint unsigned period;
      longint unsigned dead;
      longint unsigned da;
      longint unsigned db;
      int sel;
      logic sat;
      pwm_tc_pkg::rsp_payload_type r;
      clk_hz = cfg_cpu * 64'd1000000;
      sel = LADDER_STEPS - 1;
      // walk down so the first qualifying step wins
      for (int i = LADDER_STEPS - 1; i >= 0; i--) begin
         if (cfg_pwm >= clk_hz / (longint'(STEP_K[i]) * 64'd131060))
            sel = i;
      end
      k = longint'(STEP_K[sel]);
      sat = 1'b0;
      if (cfg_pwm == 0) begin
         period = 65535;
         sat = 1'b1;
      end else begin
         period = clk_hz / (64'd2 * cfg_pwm * k);
         if (period > 65535) begin
            period = 65535;
            sat = 1'b1;
         end
      end
      dead = (cfg_dead * cfg_cpu) / (64'd1000 * k);
      if (dead > 65535) begin
         dead = 65535;
         sat = 1'b1;
      end
      da = (beat.duty_a > 14'd10000) ? 64'd10000 : longint'(beat.duty_a);
      db = (beat.duty_b > 14'd10000) ? 64'd10000 : longint'(beat.duty_b);
      r.period_count        = period[15:0];
      r.high_speed_div_code = 3'(STEP_HSP[sel]);
      r.clock_div_code      = 3'(STEP_CLK[sel]);
      r.total_divide        = 10'(k);
      r.compare_a           = 16'((period * (64'd10000 - da)) / 64'd10000);
      r.compare_b           = 16'((period * (64'd10000 - db)) / 64'd10000);
      r.dead_band_count     = dead[15:0];
      r.dead_band_mode      = cfg_comp[0];
      r.saturated           = sat;
      return r;
   endfunction

   function automatic logic [13:0] pick_duty();
      case ($urandom_range(0, 15))
         0: return 14'd0;
         1: return 14'd10000;
         2, 3: return 14'($urandom_range(0, 16383));
         default: return 14'($urandom_range(0, 10000));
      endcase
   endfunction

   // Entered and left just after a falling edge.
   task automatic send_beat(input pwm_tc_pkg::req_payload_type beat, input bit known,
                            input pwm_tc_pkg::rsp_payload_type typed);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.payload = beat;
      do @(posedge clock); while (!req_if.ready);
      timing_expected.push_back(known ? typed : timing_words(beat));
      @(negedge clock);
   endtask

   // Hold requests, drain every result, then write one register.
   task automatic write_reg(input pwm_tc_pkg::csr_index_type idx, input logic [23:0] val);
      req_if.valid = 1'b0;
      while (timing_expected.size() != 0) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         pwm_tc_pkg::CSR_CPU_FREQ:      cfg_cpu  = longint'(val[7:0]);
         pwm_tc_pkg::CSR_PWM_FREQ:      cfg_pwm  = longint'(val);
         pwm_tc_pkg::CSR_DEAD_TIME:     cfg_dead = longint'(val[15:0]);
         pwm_tc_pkg::CSR_COMPLEMENTARY: cfg_comp = longint'(val[0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // Response side: random stall bursts while idling is on
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && stall_left != 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready = 1'b0;
            stall_left = $urandom_range(1, 10) - 1;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      pwm_tc_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (timing_expected.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            want = timing_expected.pop_front();
            check_field("period_count", want.period_count, rsp_if.payload.period_count);
            check_field("high_speed_div_code", want.high_speed_div_code,
                        rsp_if.payload.high_speed_div_code);
            check_field("clock_div_code", want.clock_div_code,
                        rsp_if.payload.clock_div_code);
            check_field("total_divide", want.total_divide, rsp_if.payload.total_divide);
            check_field("compare_a", want.compare_a, rsp_if.payload.compare_a);
            check_field("compare_b", want.compare_b, rsp_if.payload.compare_b);
            check_field("dead_band_count", want.dead_band_count,
                        rsp_if.payload.dead_band_count);
            check_field("dead_band_mode", want.dead_band_mode,
                        rsp_if.payload.dead_band_mode);
            check_field("saturated", want.saturated, rsp_if.payload.saturated);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int sent;
      int phase_len;
      int step;
      longint thr;
      longint target;
      logic [23:0] val;
      pwm_tc_pkg::req_payload_type beat;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CSR) begin
            write_reg(dir_table[i].idx, dir_table[i].wdata);
         end else begin
            beat.duty_a = dir_table[i].duty_a;
            beat.duty_b = dir_table[i].duty_b;
            send_beat(beat, dir_table[i].known, dir_table[i].result);
         end
      end

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 11))
               0: val = 24'd0;
               1: val = 24'd255;
               default: val = 24'($urandom_range(1, 255));
            endcase
            // upper bits beyond the register width must be ignored
            if ($urandom_range(0, 7) == 0)
               val[23:8] = 16'($urandom);
            write_reg(pwm_tc_pkg::CSR_CPU_FREQ, val);
         end
         case ($urandom_range(0, 9))
            0: val = 24'($urandom);
            1: val = 24'($urandom_range(0, 100));
            default: begin
               // land on either side of a ladder threshold
               step = $urandom_range(0, LADDER_STEPS - 1);
               thr = longint'((cfg_cpu * 64'd1000000) /
                              (longint'(STEP_K[step]) * 64'd131060));
               target = thr + longint'($urandom_range(0, 4)) - 2;
               val = (target < 0) ? 24'd0 : 24'(target);
            end
         endcase
         write_reg(pwm_tc_pkg::CSR_PWM_FREQ, val);
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
               0: val = 24'd0;
               1: val = 24'd65535;
               default: val = 24'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 7) == 0)
               val[23:16] = 8'($urandom);
            write_reg(pwm_tc_pkg::CSR_DEAD_TIME, val);
         end
         if ($urandom_range(0, 1) == 0)
            write_reg(pwm_tc_pkg::CSR_COMPLEMENTARY, 24'($urandom));

         idle_on = (sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(15, 60);
         for (int n = 0; n < phase_len; n++) begin
            beat.duty_a = pick_duty();
            beat.duty_b = pick_duty();
            send_beat(beat, 1'b0, '0);
            sent++;
         end
      end

      req_if.valid = 1'b0;
      idle_on = 1'b0;
      while (timing_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
